[design/flbs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flbs_pkg: shared definitions for the face layer blend and shade unit
// Default face size, request and register codes, controller states and the
// command, status and configuration bundles passed between the modules.
// ----------------------------------------------------------------------------
package flbs_pkg;

   localparam int FACE_WIDTH_DEF  = 64;
   localparam int FACE_HEIGHT_DEF = 32;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   // Register indexes, taken from paddr bits above the byte offset.
   localparam logic [2:0] REG_TINT_RED    = 3'd0;
   localparam logic [2:0] REG_TINT_GREEN  = 3'd1;
   localparam logic [2:0] REG_TINT_BLUE   = 3'd2;
   localparam logic [2:0] REG_MIRROR      = 3'd3;
   localparam logic [2:0] REG_CANVAS_COLS = 3'd4;

   // Request codes; the fourth code is a no-op.
   localparam logic [1:0] REQ_XFADE  = 2'd0;
   localparam logic [1:0] REQ_BLEND  = 2'd1;
   localparam logic [1:0] REQ_RENDER = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_CALC,
      ST_MUL,
      ST_PROD,
      ST_EST,
      ST_CORR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic calc;
      logic mul;
      logic done;
   } cmd_type;

   typedef struct packed {
      logic render_drawn;
   } stat_type;

   typedef struct packed {
      logic [7:0] tint_red;
      logic [7:0] tint_green;
      logic [7:0] tint_blue;
      logic       mirror_enable;
      logic [7:0] canvas_columns;
   } cfg_type;

endpackage
`default_nettype wire

[design/flbs_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flbs_csr: configuration register file
// APB-style register bank holding the material tint and the mirror setup.
// ----------------------------------------------------------------------------
module flbs_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [flbs_pkg::CSR_ADDR_W-1:0]     paddr,
   input  wire logic [flbs_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic      [flbs_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                     pready,
   output flbs_pkg::cfg_type                        cfg
);

   logic [7:0] tint_red_ff,   tint_red_in;
   logic [7:0] tint_green_ff, tint_green_in;
   logic [7:0] tint_blue_ff,  tint_blue_in;
   logic       mirror_ff,     mirror_in;
   logic [7:0] canvas_ff,     canvas_in;
   logic [2:0] reg_index;
   logic       wr_en;

   assign pready    = 1'b1;
   assign reg_index = paddr[flbs_pkg::CSR_ADDR_W-1:2];
   assign wr_en     = psel & penable & pwrite;

   always_comb begin
      tint_red_in   = tint_red_ff;
      tint_green_in = tint_green_ff;
      tint_blue_in  = tint_blue_ff;
      mirror_in     = mirror_ff;
      canvas_in     = canvas_ff;
      if (wr_en) begin
         case (reg_index)
            flbs_pkg::REG_TINT_RED:    tint_red_in   = pwdata[7:0];
            flbs_pkg::REG_TINT_GREEN:  tint_green_in = pwdata[7:0];
            flbs_pkg::REG_TINT_BLUE:   tint_blue_in  = pwdata[7:0];
            flbs_pkg::REG_MIRROR:      mirror_in     = pwdata[0];
            flbs_pkg::REG_CANVAS_COLS: canvas_in     = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tint_red_ff   <= 8'd255;
         tint_green_ff <= 8'd255;
         tint_blue_ff  <= 8'd255;
         mirror_ff     <= 1'b0;
         canvas_ff     <= 8'd128;
      end else begin
         tint_red_ff   <= tint_red_in;
         tint_green_ff <= tint_green_in;
         tint_blue_ff  <= tint_blue_in;
         mirror_ff     <= mirror_in;
         canvas_ff     <= canvas_in;
      end
   end

   always_comb begin
      case (reg_index)
         flbs_pkg::REG_TINT_RED:    prdata = {24'd0, tint_red_ff};
         flbs_pkg::REG_TINT_GREEN:  prdata = {24'd0, tint_green_ff};
         flbs_pkg::REG_TINT_BLUE:   prdata = {24'd0, tint_blue_ff};
         flbs_pkg::REG_MIRROR:      prdata = {31'd0, mirror_ff};
         flbs_pkg::REG_CANVAS_COLS: prdata = {24'd0, canvas_ff};
         default:                   prdata = '0;
      endcase
   end

   assign cfg.tint_red       = tint_red_ff;
   assign cfg.tint_green     = tint_green_ff;
   assign cfg.tint_blue      = tint_blue_ff;
   assign cfg.mirror_enable  = mirror_ff;
   assign cfg.canvas_columns = canvas_ff;

endmodule
`default_nettype wire

[design/flbs_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flbs_ctrl: transaction sequencer
// Steps one transaction through read, update and the shading multiply chain.
// ----------------------------------------------------------------------------
module flbs_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  flbs_pkg::stat_type      stat,
   output logic                    busy,
   output flbs_pkg::cmd_type       cmd
);

   flbs_pkg::state_type state_ff, state_in;

   always_comb begin
      case (state_ff)
         flbs_pkg::ST_IDLE: state_in = start ? flbs_pkg::ST_READ : flbs_pkg::ST_IDLE;
         flbs_pkg::ST_READ: state_in = flbs_pkg::ST_CALC;
         flbs_pkg::ST_CALC: state_in = stat.render_drawn ? flbs_pkg::ST_MUL
                                                         : flbs_pkg::ST_IDLE;
         flbs_pkg::ST_MUL:  state_in = flbs_pkg::ST_PROD;
         flbs_pkg::ST_PROD: state_in = flbs_pkg::ST_EST;
         flbs_pkg::ST_EST:  state_in = flbs_pkg::ST_CORR;
         flbs_pkg::ST_CORR: state_in = flbs_pkg::ST_DONE;
         flbs_pkg::ST_DONE: state_in = flbs_pkg::ST_IDLE;
         default:           state_in = flbs_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= flbs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      busy     = (state_ff != flbs_pkg::ST_IDLE);
      cmd.load = (state_ff == flbs_pkg::ST_IDLE) && start;
      cmd.read = (state_ff == flbs_pkg::ST_READ);
      cmd.calc = (state_ff == flbs_pkg::ST_CALC);
      cmd.mul  = (state_ff == flbs_pkg::ST_MUL);
      cmd.done = (state_ff == flbs_pkg::ST_DONE);
   end

endmodule
`default_nettype wire

[design/flbs_shade_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flbs_shade_lane: one color channel of the shader
// Scales the luma*cover*bright product by the tint and divides by 255^3
// with a reciprocal estimate and a one-step correction.
// ----------------------------------------------------------------------------
module flbs_shade_lane (
   input  wire logic        clock,
   input  wire logic [23:0] lcb,
   input  wire logic [7:0]  tint,
   output logic      [7:0]  level
);

   localparam logic [31:0] DIVISOR     = 32'd16581375;
   localparam logic [16:0] RECIP       = 17'd66310;
   localparam int          RECIP_SHIFT = 40;

   logic [31:0] prod_ff, prod_in;
   logic [7:0]  est_ff,  est_in;
   logic [31:0] back_ff, back_in;
   logic [48:0] scaled;
   logic [31:0] remain;

   // The estimate is never above the true quotient and at most one below.
   always_comb begin
      prod_in = {8'd0, lcb} * {24'd0, tint};
      scaled  = {17'd0, prod_ff} * {32'd0, RECIP};
      est_in  = scaled[RECIP_SHIFT+7:RECIP_SHIFT];
      back_in = {24'd0, est_ff} * DIVISOR;
      remain  = prod_ff - back_ff;
      level   = est_ff + {7'd0, (remain >= DIVISOR)};
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      est_ff  <= est_in;
      back_ff <= back_in;
   end

endmodule
`default_nettype wire

[design/flbs_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// flbs_datapath: pixel stores, blend arithmetic and shading
// Holds the transaction fields, the luminance and coverage stores, the Q.8
// mix units, the shading multiply chain and the result register.
// ----------------------------------------------------------------------------
module flbs_datapath #(
   parameter int FACE_WIDTH  = flbs_pkg::FACE_WIDTH_DEF,
   parameter int FACE_HEIGHT = flbs_pkg::FACE_HEIGHT_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  flbs_pkg::cmd_type       cmd,
   output flbs_pkg::stat_type      stat,
   input  flbs_pkg::cfg_type       cfg,
   input  wire logic [1:0]         req_type,
   input  wire logic [6:0]         req_pix_x,
   input  wire logic [4:0]         req_pix_y,
   input  wire logic [7:0]         req_luma_old,
   input  wire logic [7:0]         req_cover_old,
   input  wire logic [7:0]         req_luma_new,
   input  wire logic [7:0]         req_cover_new,
   input  wire logic [8:0]         req_mix_weight,
   input  wire logic [7:0]         req_shape_weight,
   input  wire logic signed [7:0]  req_offset_x,
   input  wire logic signed [6:0]  req_offset_y,
   input  wire logic [7:0]         req_bright_level,
   output logic                    rsp_strobe,
   output logic [7:0]              rsp_red_out,
   output logic [7:0]              rsp_green_out,
   output logic [7:0]              rsp_blue_out,
   output logic [7:0]              rsp_luma_now,
   output logic [7:0]              rsp_cover_now,
   output logic                    rsp_drawn
);

   localparam int DEPTH  = FACE_WIDTH * FACE_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = $clog2(FACE_WIDTH);
   localparam int ROW_W  = $clog2(FACE_HEIGHT);
   localparam int POS_W  = 11;

   localparam logic signed [POS_W-1:0] COL_MAX      = POS_W'(FACE_WIDTH - 1);
   localparam logic signed [POS_W-1:0] ROW_MAX      = POS_W'(FACE_HEIGHT - 1);
   localparam logic        [POS_W-1:0] FACE_COLS    = POS_W'(FACE_WIDTH);
   localparam logic        [POS_W-1:0] FACE_ROWS    = POS_W'(FACE_HEIGHT);
   localparam logic        [POS_W-1:0] MIRROR_LIMIT = POS_W'(2 * FACE_WIDTH);
   localparam logic        [POS_W-1:0] MIRROR_BASE  = POS_W'(2 * FACE_WIDTH - 1);

   // Q.8 linear mix; the accumulator stays non-negative for weights up to 256.
   function automatic logic [7:0] mix_q8(input logic [7:0] a, input logic [7:0] b,
                                         input logic [8:0] w);
      logic signed [19:0] diff;
      logic signed [19:0] wt;
      logic signed [19:0] acc;
      diff = $signed({12'd0, b}) - $signed({12'd0, a});
      wt   = $signed({11'd0, w});
      acc  = $signed({4'd0, a, 8'd0}) + diff * wt + 20'sd128;
      if (acc[19:16] != 4'd0) begin
         mix_q8 = 8'hFF;
      end else begin
         mix_q8 = acc[15:8];
      end
   endfunction

   // Transaction fields.
   logic [1:0]        type_ff;
   logic [6:0]        pix_x_ff;
   logic [4:0]        pix_y_ff;
   logic [7:0]        luma_old_ff, cover_old_ff, luma_new_ff, cover_new_ff;
   logic [8:0]        weight_ff;
   logic [7:0]        shape_ff, bright_ff;
   logic signed [7:0] offset_x_ff;
   logic signed [6:0] offset_y_ff;

   // Pixel stores.
   logic [7:0] luma_mem  [DEPTH];
   logic [7:0] cover_mem [DEPTH];
   logic [7:0] luma_rd_ff, cover_rd_ff;

   logic [8:0]  w_sat;
   logic [16:0] shape_num;
   logic [16:0] shape_div;
   logic [8:0]  we_ff, we_in;

   logic              is_write, col_in_face, row_in_face, wr_item, col_ok, render_drawn;
   logic signed [POS_W-1:0] fx, sx, sy, sx_cl, sy_cl;
   logic [COL_W-1:0]  col_sel;
   logic [ROW_W-1:0]  row_sel;
   logic [ADDR_W-1:0] addr;

   logic [7:0]  mix_a_l, mix_a_c, mix_l, mix_c;
   logic [8:0]  mix_w;
   logic [15:0] lc_ff, lc_in;
   logic [23:0] lcb_ff, lcb_in;
   logic [7:0]  lvl_red, lvl_green, lvl_blue;

   logic       strobe_ff, strobe_in;
   logic [7:0] red_ff, green_ff, blue_ff, luma_now_ff, cover_now_ff;
   logic       drawn_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         type_ff      <= req_type;
         pix_x_ff     <= req_pix_x;
         pix_y_ff     <= req_pix_y;
         luma_old_ff  <= req_luma_old;
         cover_old_ff <= req_cover_old;
         luma_new_ff  <= req_luma_new;
         cover_new_ff <= req_cover_new;
         weight_ff    <= req_mix_weight;
         shape_ff     <= req_shape_weight;
         offset_x_ff  <= req_offset_x;
         offset_y_ff  <= req_offset_y;
         bright_ff    <= req_bright_level;
      end
   end

   // Item decode and store address.
   always_comb begin
      is_write    = (type_ff == flbs_pkg::REQ_XFADE) || (type_ff == flbs_pkg::REQ_BLEND);
      col_in_face = POS_W'(pix_x_ff) < FACE_COLS;
      row_in_face = POS_W'(pix_y_ff) < FACE_ROWS;
      wr_item     = is_write && col_in_face && row_in_face;

      col_ok = 1'b0;
      fx     = '0;
      if (col_in_face) begin
         col_ok = 1'b1;
         fx     = POS_W'(pix_x_ff);
      end else if (cfg.mirror_enable && ({1'b0, pix_x_ff} < cfg.canvas_columns) &&
                   (POS_W'(pix_x_ff) < MIRROR_LIMIT)) begin
         col_ok = 1'b1;
         fx     = MIRROR_BASE - POS_W'(pix_x_ff);
      end
      render_drawn = (type_ff == flbs_pkg::REQ_RENDER) && row_in_face && col_ok;

      sx = fx - POS_W'(offset_x_ff);
      sy = $signed(POS_W'(pix_y_ff)) - POS_W'(offset_y_ff);
      if (sx[POS_W-1]) begin
         sx_cl = '0;
      end else if (sx > COL_MAX) begin
         sx_cl = COL_MAX;
      end else begin
         sx_cl = sx;
      end
      if (sy[POS_W-1]) begin
         sy_cl = '0;
      end else if (sy > ROW_MAX) begin
         sy_cl = ROW_MAX;
      end else begin
         sy_cl = sy;
      end

      if (is_write) begin
         col_sel = COL_W'(pix_x_ff);
         row_sel = ROW_W'(pix_y_ff);
      end else begin
         col_sel = COL_W'(sx_cl);
         row_sel = ROW_W'(sy_cl);
      end
      addr = ADDR_W'(ADDR_W'(row_sel) * ADDR_W'(FACE_WIDTH)) + ADDR_W'(col_sel);
   end

   assign stat.render_drawn = render_drawn;

   // Blend weight scaled by the shape level: (w*shape + 127) / 255.
   always_comb begin
      w_sat     = (weight_ff > 9'd256) ? 9'd256 : weight_ff;
      shape_num = {8'd0, w_sat} * {9'd0, shape_ff} + 17'd127;
      shape_div = shape_num + (shape_num >> 8) + 17'd1;
      we_in     = shape_div[16:8];
   end

   always_ff @(posedge clock) begin
      if (cmd.read) begin
         we_ff       <= we_in;
         luma_rd_ff  <= luma_mem[addr];
         cover_rd_ff <= cover_mem[addr];
      end
   end

   always_comb begin
      if (type_ff == flbs_pkg::REQ_BLEND) begin
         mix_a_l = luma_rd_ff;
         mix_a_c = cover_rd_ff;
         mix_w   = we_ff;
      end else begin
         mix_a_l = luma_old_ff;
         mix_a_c = cover_old_ff;
         mix_w   = w_sat;
      end
      mix_l = mix_q8(mix_a_l, luma_new_ff, mix_w);
      mix_c = mix_q8(mix_a_c, cover_new_ff, mix_w);
   end

   always_ff @(posedge clock) begin
      if (cmd.calc && wr_item) begin
         luma_mem[addr]  <= mix_l;
         cover_mem[addr] <= mix_c;
      end
   end

   // Shading chain: luma*cover, then *bright, then per channel in the lanes.
   always_comb begin
      lc_in  = {8'd0, luma_rd_ff} * {8'd0, cover_rd_ff};
      lcb_in = {8'd0, lc_ff} * {16'd0, bright_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         lc_ff <= lc_in;
      end
      if (cmd.mul) begin
         lcb_ff <= lcb_in;
      end
   end

   flbs_shade_lane u_lane_red (
      .clock (clock),
      .lcb   (lcb_ff),
      .tint  (cfg.tint_red),
      .level (lvl_red)
   );

   flbs_shade_lane u_lane_green (
      .clock (clock),
      .lcb   (lcb_ff),
      .tint  (cfg.tint_green),
      .level (lvl_green)
   );

   flbs_shade_lane u_lane_blue (
      .clock (clock),
      .lcb   (lcb_ff),
      .tint  (cfg.tint_blue),
      .level (lvl_blue)
   );

   // Result register.
   assign strobe_in = (cmd.calc && !render_drawn) || cmd.done;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.done) begin
         red_ff       <= lvl_red;
         green_ff     <= lvl_green;
         blue_ff      <= lvl_blue;
         luma_now_ff  <= luma_rd_ff;
         cover_now_ff <= cover_rd_ff;
         drawn_ff     <= 1'b1;
      end else if (cmd.calc) begin
         red_ff       <= '0;
         green_ff     <= '0;
         blue_ff      <= '0;
         luma_now_ff  <= wr_item ? mix_l : 8'd0;
         cover_now_ff <= wr_item ? mix_c : 8'd0;
         drawn_ff     <= 1'b0;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_red_out   = red_ff;
   assign rsp_green_out = green_ff;
   assign rsp_blue_out  = blue_ff;
   assign rsp_luma_now  = luma_now_ff;
   assign rsp_cover_now = cover_now_ff;
   assign rsp_drawn     = drawn_ff;

endmodule
`default_nettype wire

[design/face_layer_blend_and_shade_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// face_layer_blend_and_shade_unit: face layer blend and shade top level
// Keeps per-pixel luminance and coverage stores for an animated face, loads
// crossfades into them, blends overlays over them and renders tinted pixels.
// ----------------------------------------------------------------------------
//
// Channel      Ports                         Transfer
// request      start, busy, req_*            start high while busy is low
// result       rsp_strobe, rsp_*             one cycle with rsp_strobe high
// registers    psel, penable, pwrite, ...    APB write at access, pready high
//
// A crossfade, blend, no-op or undrawn render transaction goes through the
// capture, the store read and the update step before its result strobe; a
// drawn render also runs the shading multiply chain and the reciprocal
// divide by 255^3 in each color lane. The store read is registered.
// Reset clears the controller and the result strobe and returns the registers to their defaults; the
// pixel stores are not cleared and must be written before they are read.
// The receiver cannot stall: each result is shown for exactly one cycle, in
// the cycle where busy has already dropped, so a new transaction may start.
//
module face_layer_blend_and_shade_unit #(
   parameter int FACE_WIDTH  = flbs_pkg::FACE_WIDTH_DEF,
   parameter int FACE_HEIGHT = flbs_pkg::FACE_HEIGHT_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // Request channel.
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_type,
   input  wire logic [6:0]                       req_pix_x,
   input  wire logic [4:0]                       req_pix_y,
   input  wire logic [7:0]                       req_luma_old,
   input  wire logic [7:0]                       req_cover_old,
   input  wire logic [7:0]                       req_luma_new,
   input  wire logic [7:0]                       req_cover_new,
   input  wire logic [8:0]                       req_mix_weight,
   input  wire logic [7:0]                       req_shape_weight,
   input  wire logic signed [7:0]                req_offset_x,
   input  wire logic signed [6:0]                req_offset_y,
   input  wire logic [7:0]                       req_bright_level,
   // Result channel.
   output logic                                  rsp_strobe,
   output logic [7:0]                            rsp_red_out,
   output logic [7:0]                            rsp_green_out,
   output logic [7:0]                            rsp_blue_out,
   output logic [7:0]                            rsp_luma_now,
   output logic [7:0]                            rsp_cover_now,
   output logic                                  rsp_drawn,
   // Register port.
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [flbs_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [flbs_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic      [flbs_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                                  pready
);

   flbs_pkg::cfg_type  cfg;
   flbs_pkg::cmd_type  cmd;
   flbs_pkg::stat_type stat;

   // The register bank feeds the tint and mirror settings to the datapath.
   // Software must write it only while no transaction is in flight; the block does not enforce this.
   flbs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // The controller sequences each transaction: capture, store read, update
   // or shading steps, and the result load.
   flbs_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .busy  (busy),
      .cmd   (cmd)
   );

   // The datapath owns the pixel stores, the mix units and the shader lanes.
   flbs_datapath #(
      .FACE_WIDTH  (FACE_WIDTH),
      .FACE_HEIGHT (FACE_HEIGHT)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cfg              (cfg),
      .req_type         (req_type),
      .req_pix_x        (req_pix_x),
      .req_pix_y        (req_pix_y),
      .req_luma_old     (req_luma_old),
      .req_cover_old    (req_cover_old),
      .req_luma_new     (req_luma_new),
      .req_cover_new    (req_cover_new),
      .req_mix_weight   (req_mix_weight),
      .req_shape_weight (req_shape_weight),
      .req_offset_x     (req_offset_x),
      .req_offset_y     (req_offset_y),
      .req_bright_level (req_bright_level),
      .rsp_strobe       (rsp_strobe),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_luma_now     (rsp_luma_now),
      .rsp_cover_now    (rsp_cover_now),
      .rsp_drawn        (rsp_drawn)
   );

   // A result is only shown once the controller is back in idle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while a transaction is in flight");

   // An accepted transaction keeps the unit busy in the following cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_strobe))
      else $error("accepted transaction did not occupy the unit");

   // Each transaction produces one strobe, never two in a row.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe repeated");

   // Undrawn results carry no color.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_drawn) |->
         (rsp_red_out == 8'd0 && rsp_green_out == 8'd0 && rsp_blue_out == 8'd0))
      else $error("color on an undrawn result");

endmodule
`default_nettype wire

[sim/face_pixel_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// face_pixel_checker: result checker for the face layer blend and shade unit
// Tracks register writes and accepted requests, keeps its own copy of the
// luminance and coverage stores, and matches each result strobe against the
// oldest predicted pixel.
// ----------------------------------------------------------------------------
module face_pixel_checker #(
   parameter int FACE_WIDTH  = flbs_pkg::FACE_WIDTH_DEF,
   parameter int FACE_HEIGHT = flbs_pkg::FACE_HEIGHT_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [1:0]                           req_type,
   input  logic [6:0]                           req_pix_x,
   input  logic [4:0]                           req_pix_y,
   input  logic [7:0]                           req_luma_old,
   input  logic [7:0]                           req_cover_old,
   input  logic [7:0]                           req_luma_new,
   input  logic [7:0]                           req_cover_new,
   input  logic [8:0]                           req_mix_weight,
   input  logic [7:0]                           req_shape_weight,
   input  logic signed [7:0]                    req_offset_x,
   input  logic signed [6:0]                    req_offset_y,
   input  logic [7:0]                           req_bright_level,
   input  logic                                 rsp_strobe,
   input  logic [7:0]                           rsp_red_out,
   input  logic [7:0]                           rsp_green_out,
   input  logic [7:0]                           rsp_blue_out,
   input  logic [7:0]                           rsp_luma_now,
   input  logic [7:0]                           rsp_cover_now,
   input  logic                                 rsp_drawn,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [flbs_pkg::CSR_ADDR_W-1:0]      paddr,
   input  logic [flbs_pkg::CSR_DATA_W-1:0]      pwdata,
   input  logic                                 pready,
   output int                                   mismatches,
   output int                                   pending
);

   localparam int     STORE_DEPTH = FACE_WIDTH * FACE_HEIGHT;
   localparam longint CUBE_255    = 64'd16581375;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] luma;
      logic [7:0] cvg;
      logic       drawn;
   } pixel_result_type;

   logic [7:0]       luma_mem  [STORE_DEPTH];
   logic [7:0]       cover_mem [STORE_DEPTH];
   logic [7:0]       tint_r, tint_g, tint_b, canvas_cols;
   logic             mirror_on;
   pixel_result_type expected_pixels [$];
   int               result_count;

   // Q.8 linear mix; the sum is never negative for weights up to 256.
   function automatic logic [7:0] mix_q8(int a, int b, int w);
      int v;
      v = (a * 256 + (b - a) * w + 128) / 256;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   function automatic logic [7:0] shade_channel(logic [7:0] tint, logic [7:0] l,
                                                logic [7:0] c, logic [7:0] bright);
      longint q;
      q = (longint'(tint) * l * c * bright) / CUBE_255;
      return q[7:0];
   endfunction

   // Works out the result of the request on the ports and applies its store write.
   function automatic pixel_result_type predict_pixel();
      pixel_result_type res;
      int w, we, fx, sx, sy, slot;
      res = '0;
      w = (req_mix_weight > 9'd256) ? 256 : int'(req_mix_weight);
      if (req_type == flbs_pkg::REQ_XFADE || req_type == flbs_pkg::REQ_BLEND) begin
         if (req_pix_x < FACE_WIDTH && req_pix_y < FACE_HEIGHT) begin
            slot = int'(req_pix_y) * FACE_WIDTH + int'(req_pix_x);
            if (req_type == flbs_pkg::REQ_XFADE) begin
               luma_mem[slot]  = mix_q8(int'(req_luma_old), int'(req_luma_new), w);
               cover_mem[slot] = mix_q8(int'(req_cover_old), int'(req_cover_new), w);
            end else if (req_shape_weight != 8'd0) begin
               we = (w * int'(req_shape_weight) + 127) / 255;
               luma_mem[slot]  = mix_q8(int'(luma_mem[slot]), int'(req_luma_new), we);
               cover_mem[slot] = mix_q8(int'(cover_mem[slot]), int'(req_cover_new), we);
            end
            res.luma = luma_mem[slot];
            res.cvg  = cover_mem[slot];
         end
      end else if (req_type == flbs_pkg::REQ_RENDER && req_pix_y < FACE_HEIGHT) begin
         fx = -1;
         if (req_pix_x < FACE_WIDTH) begin
            fx = int'(req_pix_x);
         end else if (mirror_on && req_pix_x < canvas_cols && req_pix_x < 2 * FACE_WIDTH) begin
            fx = 2 * FACE_WIDTH - 1 - int'(req_pix_x);
         end
         if (fx >= 0) begin
            sx = fx - int'(req_offset_x);
            sy = int'(req_pix_y) - int'(req_offset_y);
            sx = (sx < 0) ? 0 : (sx > FACE_WIDTH - 1) ? FACE_WIDTH - 1 : sx;
            sy = (sy < 0) ? 0 : (sy > FACE_HEIGHT - 1) ? FACE_HEIGHT - 1 : sy;
            slot      = sy * FACE_WIDTH + sx;
            res.luma  = luma_mem[slot];
            res.cvg   = cover_mem[slot];
            res.red   = shade_channel(tint_r, res.luma, res.cvg, req_bright_level);
            res.green = shade_channel(tint_g, res.luma, res.cvg, req_bright_level);
            res.blue  = shade_channel(tint_b, res.luma, res.cvg, req_bright_level);
            res.drawn = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want) begin
         report_mismatch($sformatf("result %0d %s = %0d, expected %0d",
                                   result_count, name, got, want));
      end
   endtask

   always @(posedge clock) begin
      pixel_result_type want;
      if (reset) begin
         tint_r      = 8'd255;
         tint_g      = 8'd255;
         tint_b      = 8'd255;
         mirror_on   = 1'b0;
         canvas_cols = 8'd128;
         expected_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[flbs_pkg::CSR_ADDR_W-1:2])
               flbs_pkg::REG_TINT_RED:    tint_r      = pwdata[7:0];
               flbs_pkg::REG_TINT_GREEN:  tint_g      = pwdata[7:0];
               flbs_pkg::REG_TINT_BLUE:   tint_b      = pwdata[7:0];
               flbs_pkg::REG_MIRROR:      mirror_on   = pwdata[0];
               flbs_pkg::REG_CANVAS_COLS: canvas_cols = pwdata[7:0];
               default: ;
            endcase
         end
         // A result may retire in the same edge as the next request is taken.
         if (rsp_strobe) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                         result_count));
            end else begin
               want = expected_pixels.pop_front();
               compare_field("red_out", int'(rsp_red_out), int'(want.red));
               compare_field("green_out", int'(rsp_green_out), int'(want.green));
               compare_field("blue_out", int'(rsp_blue_out), int'(want.blue));
               compare_field("luma_now", int'(rsp_luma_now), int'(want.luma));
               compare_field("cover_now", int'(rsp_cover_now), int'(want.cvg));
               compare_field("drawn", int'(rsp_drawn), int'(want.drawn));
            end
            result_count++;
         end
         if (start && !busy) begin
            expected_pixels.push_back(predict_pixel());
         end
      end
      pending = expected_pixels.size();
   end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the face layer blend and shade unit
// Drives crossfade, blend, render and no-op transactions with random idle
// gaps across several register settings; a separate checker predicts every
// result and counts mismatches, and this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int FACE_W           = flbs_pkg::FACE_WIDTH_DEF;
   localparam int FACE_H           = flbs_pkg::FACE_HEIGHT_DEF;
   localparam int STORE_DEPTH      = FACE_W * FACE_H;
   localparam int RANDOM_PER_PHASE = 84;
   localparam int PHASES           = 5;
   localparam int CYCLE_LIMIT      = 400000;
   // The fourth request code has no name in the package; it is a no-op.
   localparam logic [1:0] REQ_NOP  = 2'd3;

   // One request transaction as it appears on the req_ ports.
   typedef struct packed {
      logic [1:0] kind;
      logic [6:0] pix_x;
      logic [4:0] pix_y;
      logic [7:0] luma_old;
      logic [7:0] cover_old;
      logic [7:0] luma_new;
      logic [7:0] cover_new;
      logic [8:0] mix_weight;
      logic [7:0] shape_weight;
      logic [7:0] offset_x;
      logic [6:0] offset_y;
      logic [7:0] bright_level;
   } pixel_cmd_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_type;
   logic [6:0]  req_pix_x;
   logic [4:0]  req_pix_y;
   logic [7:0]  req_luma_old, req_cover_old, req_luma_new, req_cover_new;
   logic [8:0]  req_mix_weight;
   logic [7:0]  req_shape_weight;
   logic signed [7:0] req_offset_x;
   logic signed [6:0] req_offset_y;
   logic [7:0]  req_bright_level;
   logic        rsp_strobe;
   logic [7:0]  rsp_red_out, rsp_green_out, rsp_blue_out, rsp_luma_now, rsp_cover_now;
   logic        rsp_drawn;
   logic        psel, penable, pwrite, pready;
   logic [flbs_pkg::CSR_ADDR_W-1:0] paddr;
   logic [flbs_pkg::CSR_DATA_W-1:0] pwdata, prdata;

   int check_failures;
   int pending;
   int cycle_count;
   int kind_count [4];
   int settings_count;

   // The stores power up undefined, so the stimulus keeps its own map of the
   // entries that a crossfade has written and never reads anything else.
   bit         written_map [STORE_DEPTH];
   // Copies of the mirror registers, needed to know where a render samples.
   logic       mirror_on;
   logic [7:0] canvas_cols;
   // When set, transactions go back to back with no idle cycles.
   bit         steady;

   face_layer_blend_and_shade_unit dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_pix_x        (req_pix_x),
      .req_pix_y        (req_pix_y),
      .req_luma_old     (req_luma_old),
      .req_cover_old    (req_cover_old),
      .req_luma_new     (req_luma_new),
      .req_cover_new    (req_cover_new),
      .req_mix_weight   (req_mix_weight),
      .req_shape_weight (req_shape_weight),
      .req_offset_x     (req_offset_x),
      .req_offset_y     (req_offset_y),
      .req_bright_level (req_bright_level),
      .rsp_strobe       (rsp_strobe),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_luma_now     (rsp_luma_now),
      .rsp_cover_now    (rsp_cover_now),
      .rsp_drawn        (rsp_drawn),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // The checker watches the same wires as the block and reports back only
   // its mismatch count and the number of results still outstanding.
   face_pixel_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_type         (req_type),
      .req_pix_x        (req_pix_x),
      .req_pix_y        (req_pix_y),
      .req_luma_old     (req_luma_old),
      .req_cover_old    (req_cover_old),
      .req_luma_new     (req_luma_new),
      .req_cover_new    (req_cover_new),
      .req_mix_weight   (req_mix_weight),
      .req_shape_weight (req_shape_weight),
      .req_offset_x     (req_offset_x),
      .req_offset_y     (req_offset_y),
      .req_bright_level (req_bright_level),
      .rsp_strobe       (rsp_strobe),
      .rsp_red_out      (rsp_red_out),
      .rsp_green_out    (rsp_green_out),
      .rsp_blue_out     (rsp_blue_out),
      .rsp_luma_now     (rsp_luma_now),
      .rsp_cover_now    (rsp_cover_now),
      .rsp_drawn        (rsp_drawn),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .pready           (pready),
      .mismatches       (check_failures),
      .pending          (pending)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Watchdog. The slowest legal run is far below this, with under a thousand
   // transactions and their idle gaps.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, pending);
         $display("FAILURE");
         $finish;
      end
   end

   function automatic pixel_cmd_type pixel_cmd(logic [1:0] kind, int px, int py, int lo,
                                               int co, int ln, int cn, int w, int shape,
                                               int ox, int oy, int bright);
      pixel_cmd_type c;
      c.kind         = kind;
      c.pix_x        = px[6:0];
      c.pix_y        = py[4:0];
      c.luma_old     = lo[7:0];
      c.cover_old    = co[7:0];
      c.luma_new     = ln[7:0];
      c.cover_new    = cn[7:0];
      c.mix_weight   = w[8:0];
      c.shape_weight = shape[7:0];
      c.offset_x     = ox[7:0];
      c.offset_y     = oy[6:0];
      c.bright_level = bright[7:0];
      return c;
   endfunction

   // Random transaction. Half of the pixels fall in a small hot window so
   // that blends stack on earlier writes and renders see blended values.
   // Weights, shape levels and brightness lean on their end values; offsets
   // are mostly small wiggles, sometimes the full shift range and now and
   // then any value the field can carry.
   function automatic pixel_cmd_type random_pixel_cmd();
      pixel_cmd_type c;
      int roll;
      bit hot;
      roll = $urandom_range(0, 99);
      hot  = ($urandom_range(0, 1) == 1);
      c.kind = (roll < 28) ? flbs_pkg::REQ_XFADE : (roll < 55) ? flbs_pkg::REQ_BLEND :
               (roll < 95) ? flbs_pkg::REQ_RENDER : REQ_NOP;
      if (hot) begin
         c.pix_x = 7'($urandom_range(20, 27));
         c.pix_y = 5'($urandom_range(10, 13));
      end else begin
         c.pix_y = 5'($urandom_range(0, 31));
         if (c.kind == flbs_pkg::REQ_RENDER || $urandom_range(0, 99) < 15) begin
            c.pix_x = 7'($urandom_range(0, 127));
         end else begin
            c.pix_x = 7'($urandom_range(0, 63));
         end
      end
      c.luma_old  = 8'($urandom_range(0, 255));
      c.cover_old = 8'($urandom_range(0, 255));
      c.luma_new  = 8'($urandom_range(0, 255));
      c.cover_new = 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 9);
      c.mix_weight = (roll == 0) ? 9'd0 : (roll == 1) ? 9'd256 :
                     (roll == 2) ? 9'($urandom_range(257, 511)) : 9'($urandom_range(0, 256));
      roll = $urandom_range(0, 9);
      c.shape_weight = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 9);
      c.bright_level = (roll == 0) ? 8'd0 : (roll == 1) ? 8'd255 : 8'($urandom_range(0, 255));
      roll = $urandom_range(0, 9);
      if (roll < 7) begin
         c.offset_x = 8'($urandom_range(0, 6) - 3);
         c.offset_y = 7'($urandom_range(0, 6) - 3);
      end else if (roll < 9) begin
         c.offset_x = 8'($urandom_range(0, 128) - 64);
         c.offset_y = 7'($urandom_range(0, 64) - 32);
      end else begin
         c.offset_x = 8'($urandom_range(0, 255));
         c.offset_y = 7'($urandom_range(0, 127));
      end
      return c;
   endfunction

   // Store entry that a transaction reads, or -1 if it reads none.
   function automatic int sample_slot(pixel_cmd_type c);
      int fx, sx, sy;
      if (c.kind == flbs_pkg::REQ_BLEND) begin
         return (c.pix_x < FACE_W) ? int'(c.pix_y) * FACE_W + int'(c.pix_x) : -1;
      end
      if (c.kind != flbs_pkg::REQ_RENDER) begin
         return -1;
      end
      fx = -1;
      if (c.pix_x < FACE_W) begin
         fx = int'(c.pix_x);
      end else if (mirror_on && c.pix_x < canvas_cols && c.pix_x < 2 * FACE_W) begin
         fx = 2 * FACE_W - 1 - int'(c.pix_x);
      end
      if (fx < 0) begin
         return -1;
      end
      sx = fx - int'($signed(c.offset_x));
      sy = int'(c.pix_y) - int'($signed(c.offset_y));
      sx = (sx < 0) ? 0 : (sx > FACE_W - 1) ? FACE_W - 1 : sx;
      sy = (sy < 0) ? 0 : (sy > FACE_H - 1) ? FACE_H - 1 : sy;
      return sy * FACE_W + sx;
   endfunction

   // Presents one transaction from the falling edge and holds it until the
   // block takes it. start is left high, so a following transaction goes
   // out back to back unless a gap is drawn here.
   task automatic drive_cmd(input pixel_cmd_type c);
      int roll, gap;
      @(negedge clock);
      start            = 1'b1;
      req_type         = c.kind;
      req_pix_x        = c.pix_x;
      req_pix_y        = c.pix_y;
      req_luma_old     = c.luma_old;
      req_cover_old    = c.cover_old;
      req_luma_new     = c.luma_new;
      req_cover_new    = c.cover_new;
      req_mix_weight   = c.mix_weight;
      req_shape_weight = c.shape_weight;
      req_offset_x     = c.offset_x;
      req_offset_y     = c.offset_y;
      req_bright_level = c.bright_level;
      @(posedge clock);
      while (busy) @(posedge clock);
      kind_count[c.kind]++;
      if (c.kind == flbs_pkg::REQ_XFADE && c.pix_x < FACE_W && c.pix_y < FACE_H) begin
         written_map[int'(c.pix_y) * FACE_W + int'(c.pix_x)] = 1'b1;
      end
      // Mostly short gaps, a few long ones, none at all in steady stretches.
      roll = $urandom_range(0, 99);
      gap  = steady ? 0 : (roll < 55) ? 0 : (roll < 88) ? $urandom_range(1, 3) :
             $urandom_range(6, 40);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Sends a transaction, first loading the entry it reads with a random
   // crossfade if that entry has never been written.
   task automatic issue_cmd(input pixel_cmd_type c);
      int slot;
      pixel_cmd_type fill;
      slot = sample_slot(c);
      if (slot >= 0 && !written_map[slot]) begin
         fill       = random_pixel_cmd();
         fill.kind  = flbs_pkg::REQ_XFADE;
         fill.pix_x = 7'(slot % FACE_W);
         fill.pix_y = 5'(slot / FACE_W);
         drive_cmd(fill);
      end
      drive_cmd(c);
   endtask

   // Lets every outstanding result retire, then idles past the longest
   // latency of the block so it is surely at rest.
   task automatic wait_drained();
      @(negedge clock);
      start = 1'b0;
      while (pending != 0 || busy) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle until pready is seen high.
   task automatic csr_write(input logic [2:0] index, input int value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = {index, 2'b00};
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic apply_setting(input int tint_r, input int tint_g, input int tint_b,
                                input int mirror, input int cols);
      csr_write(flbs_pkg::REG_TINT_RED, tint_r);
      csr_write(flbs_pkg::REG_TINT_GREEN, tint_g);
      csr_write(flbs_pkg::REG_TINT_BLUE, tint_b);
      csr_write(flbs_pkg::REG_MIRROR, mirror);
      csr_write(flbs_pkg::REG_CANVAS_COLS, cols);
      mirror_on   = mirror[0];
      canvas_cols = cols[7:0];
      settings_count++;
   endtask

   initial begin
      int p, i;
      reset            = 1'b1;
      start            = 1'b0;
      req_type         = flbs_pkg::REQ_XFADE;
      req_pix_x        = '0;
      req_pix_y        = '0;
      req_luma_old     = '0;
      req_cover_old    = '0;
      req_luma_new     = '0;
      req_cover_new    = '0;
      req_mix_weight   = '0;
      req_shape_weight = '0;
      req_offset_x     = '0;
      req_offset_y     = '0;
      req_bright_level = '0;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      mirror_on        = 1'b0;
      canvas_cols      = 8'd128;
      steady           = 1'b0;
      settings_count   = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed transactions with the reset register values: white tint,
      // mirroring off. Crossfades at weight zero, full swap and half way,
      // and with a weight above 256 that must saturate.
      issue_cmd(pixel_cmd(flbs_pkg::REQ_XFADE, 0, 0, 0, 0, 255, 255, 0, 0, 0, 0, 0));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_XFADE, 63, 31, 0, 0, 255, 255, 256, 0, 0, 0, 0));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_XFADE, 10, 5, 255, 0, 0, 255, 128, 0, 0, 0, 0));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_XFADE, 1, 0, 17, 240, 200, 3, 511, 0, 0, 0, 0));
      // Writes outside the face are dropped and return all zeros.
      issue_cmd(pixel_cmd(flbs_pkg::REQ_XFADE, 64, 0, 255, 255, 255, 255, 256, 255,
                          -1, -1, 255));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_XFADE, 127, 31, 255, 255, 255, 255, 256, 255,
                          -1, -1, 255));
      // Blends: shape level zero leaves the pixel alone, full shape with full
      // weight, a weight that rounds to nothing, a saturated weight, and a
      // blend outside the face.
      issue_cmd(pixel_cmd(flbs_pkg::REQ_BLEND, 10, 5, 0, 0, 200, 100, 256, 0, 0, 0, 0));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_BLEND, 10, 5, 0, 0, 200, 100, 256, 255, 0, 0, 0));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_BLEND, 0, 0, 0, 0, 255, 255, 1, 1, 0, 0, 0));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_BLEND, 63, 31, 0, 0, 0, 0, 300, 128, 0, 0, 0));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_BLEND, 100, 7, 0, 0, 255, 255, 256, 255, 0, 0, 0));
      // Renders at the face corners, with shifts that clamp at every edge,
      // with the widest shifts the fields carry, and at zero brightness.
      issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 255));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 63, 31, 0, 0, 0, 0, 0, 0, 0, 0, 255));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, 64, 32, 255));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 63, 31, 0, 0, 0, 0, 0, 0, -64, -32, 255));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 0, 0, 0, 0, 0, 0, 0, 0, -128, -64, 128));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 10, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // Right-half columns are not drawn while mirroring is off.
      issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 64, 3, 0, 0, 0, 0, 0, 0, 0, 0, 255));
      issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 127, 31, 0, 0, 0, 0, 0, 0, 127, 63, 255));
      // The spare request code does nothing, whatever the other fields say.
      issue_cmd(pixel_cmd(REQ_NOP, 127, 31, 255, 255, 255, 255, 511, 255, -1, -1, 255));
      wait_drained();

      // Random phases, each under its own register setting, written while
      // the block is idle.
      for (p = 0; p < PHASES; p++) begin
         case (p)
            0: apply_setting(200, 0, 255, 1, 128);
            1: apply_setting(0, 0, 0, 1, 64);
            2: apply_setting($urandom_range(0, 255), $urandom_range(0, 255),
                             $urandom_range(0, 255), 1, $urandom_range(65, 127));
            3: apply_setting(255, 255, 255, 0, 128);
            default: apply_setting($urandom_range(0, 255), $urandom_range(0, 255),
                                   $urandom_range(0, 255), $urandom_range(0, 1),
                                   $urandom_range(64, 128));
         endcase
         steady = 1'b0;
         // Mirrored columns at both ends of the right half, and the column
         // on either side of the canvas edge.
         if (p == 0) begin
            issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 64, 9, 0, 0, 0, 0, 0, 0, 0, 0, 255));
            issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 127, 9, 0, 0, 0, 0, 0, 0, 0, 0, 255));
            issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 100, 12, 0, 0, 0, 0, 0, 0, 2, -1, 255));
            issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 63, 9, 0, 0, 0, 0, 0, 0, 0, 0, 255));
         end else if (p == 1) begin
            issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 64, 9, 0, 0, 0, 0, 0, 0, 0, 0, 255));
            issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, 127, 9, 0, 0, 0, 0, 0, 0, 0, 0, 255));
         end else if (p == 2) begin
            issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, canvas_cols - 1, 4, 0, 0, 0, 0, 0, 0,
                                0, 0, 255));
            issue_cmd(pixel_cmd(flbs_pkg::REQ_RENDER, canvas_cols, 4, 0, 0, 0, 0, 0, 0,
                                0, 0, 255));
         end
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            // Roughly one stretch in four runs with no idle cycles at all.
            if (i % 32 == 0) begin
               steady = ($urandom_range(0, 3) == 0);
            end
            issue_cmd(random_pixel_cmd());
         end
         wait_drained();
      end

      $display("Run covered %0d transactions: %0d crossfade, %0d blend, %0d render, %0d no-op,",
               kind_count[flbs_pkg::REQ_XFADE] + kind_count[flbs_pkg::REQ_BLEND] +
               kind_count[flbs_pkg::REQ_RENDER] + kind_count[REQ_NOP],
               kind_count[flbs_pkg::REQ_XFADE], kind_count[flbs_pkg::REQ_BLEND],
               kind_count[flbs_pkg::REQ_RENDER], kind_count[REQ_NOP]);
      $display("under %0d register settings, with %0d mismatches and %0d results missing.",
               settings_count, check_failures, pending);
      if (check_failures == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
